// File: hdl/slafp_pkg.sv
// Shared constants for the sync, length and address frame parser.
// Used by the top level; depends on nothing.
package slafp_pkg;

   localparam int MAX_PAYLOAD = 32;
   localparam int STORE_ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

   localparam int BYTE_W = 8;
   localparam int PLEN_FIELD_W = 6;
   localparam int INDEX_FIELD_W = 5;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USED_W = BYTE_W + PLEN_FIELD_W + INDEX_FIELD_W + BYTE_W;

   localparam logic CSR_SYNC_HIGH = 1'b0;
   localparam logic CSR_SYNC_LOW = 1'b1;

   localparam logic [BYTE_W-1:0] SYNC_HIGH_RESET = 8'd170;
   localparam logic [BYTE_W-1:0] SYNC_LOW_RESET = 8'd85;

endpackage

// File: hdl/sync_length_address_frame_parser.sv
// Top level of the sync, length and address frame parser.
// Depends on slafp_pkg and on the generic RAM slafp_ram for the payload store.
//
//   Channel   Direction  Handshake                Payload
//   req       in         req_tvalid/req_tready    tdata: rx_byte
//   rsp       out        rsp_tvalid/rsp_tready    tdata: address, length, index, data; tlast
//   csr       in         csr_we                   csr_index, csr_wdata
//
// Header and payload bytes take one cycle each when the result register is free.
// Replay of a stored frame passes through ST_WAIT and ST_SEND for each result, as the
// payload RAM has a registered read; req_tready is low during the replay.
// An empty frame gives its single result directly from the address byte.
// Reset is synchronous; the payload RAM is not cleared and needs no clearing pass.
// A stalled result holds in the output register and blocks further items.
module sync_length_address_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] node_address, [13:8] payload_length,
                                    // [18:14] byte_index, [26:19] data_byte, [31:27] zero
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_LEN,
      ST_ADDR,
      ST_DATA,
      ST_WAIT,
      ST_SEND
   } state_type;

   localparam int AW = slafp_pkg::STORE_ADDR_W;
   localparam int LW = slafp_pkg::LEN_W;
   localparam int BW = slafp_pkg::BYTE_W;

   state_type state_ff, state_in;
   logic [BW-1:0] sync_high_byte_ff, sync_high_byte_in;
   logic [BW-1:0] sync_low_byte_ff, sync_low_byte_in;
   logic armed_ff, armed_in;
   logic [LW-1:0] len_ff, len_in;
   logic [BW-1:0] addr_ff, addr_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [LW-1:0] rd_idx_ff, rd_idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_addr_ff, rsp_addr_in;
   logic [slafp_pkg::PLEN_FIELD_W-1:0] rsp_len_ff, rsp_len_in;
   logic [slafp_pkg::INDEX_FIELD_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [BW-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_last_ff, rsp_last_in;

   logic out_free;
   logic accept;
   logic ram_we;
   logic [BW-1:0] ram_rdata;
   logic [LW-1:0] fill_next;
   logic [LW-1:0] rd_idx_next;

   slafp_ram #(
      .WIDTH(BW),
      .DEPTH(slafp_pkg::MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = out_free && (state_ff != ST_WAIT) && (state_ff != ST_SEND);
   assign accept = req_tvalid && req_tready;
   assign ram_we = accept && (state_ff == ST_DATA);
   assign fill_next = fill_ff + LW'(1);
   assign rd_idx_next = rd_idx_ff + LW'(1);

   always_comb begin
      state_in = state_ff;
      armed_in = armed_ff;
      len_in = len_ff;
      addr_in = addr_ff;
      fill_in = fill_ff;
      rd_idx_in = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_addr_in = rsp_addr_ff;
      rsp_len_in = rsp_len_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      sync_high_byte_in = sync_high_byte_ff;
      sync_low_byte_in = sync_low_byte_ff;

      if (csr_we) begin
         case (csr_index)
            slafp_pkg::CSR_SYNC_HIGH: sync_high_byte_in = csr_wdata;
            slafp_pkg::CSR_SYNC_LOW:  sync_low_byte_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_HUNT: begin
            if (accept) begin
               if (armed_ff && req_tdata == sync_low_byte_ff) begin
                  state_in = ST_LEN;
               end else if (req_tdata == sync_high_byte_ff) begin
                  armed_in = 1'b1;
               end
            end
         end
         ST_LEN: begin
            if (accept) begin
               if (32'(req_tdata) > 32'(slafp_pkg::MAX_PAYLOAD)) begin
                  state_in = ST_HUNT;
                  armed_in = 1'b0;
                  len_in = '0;
                  addr_in = '0;
                  fill_in = '0;
               end else begin
                  len_in = LW'(req_tdata);
                  state_in = ST_ADDR;
               end
            end
         end
         ST_ADDR: begin
            if (accept) begin
               if (len_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_addr_in = req_tdata;
                  rsp_len_in = '0;
                  rsp_idx_in = '0;
                  rsp_data_in = '0;
                  rsp_last_in = 1'b1;
                  state_in = ST_HUNT;
                  armed_in = 1'b0;
                  len_in = '0;
                  addr_in = '0;
                  fill_in = '0;
               end else begin
                  addr_in = req_tdata;
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (accept) begin
               fill_in = fill_next;
               if (fill_next >= len_ff) begin
                  rd_idx_in = '0;
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in = addr_ff;
               rsp_len_in = slafp_pkg::PLEN_FIELD_W'(len_ff);
               rsp_idx_in = slafp_pkg::INDEX_FIELD_W'(rd_idx_ff);
               rsp_data_in = ram_rdata;
               rsp_last_in = (rd_idx_next == len_ff);
               if (rd_idx_next == len_ff) begin
                  state_in = ST_HUNT;
                  armed_in = 1'b0;
                  len_in = '0;
                  addr_in = '0;
                  fill_in = '0;
               end else begin
                  rd_idx_in = rd_idx_next;
                  state_in = ST_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         armed_ff <= 1'b0;
         len_ff <= '0;
         addr_ff <= '0;
         fill_ff <= '0;
         rd_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         sync_high_byte_ff <= slafp_pkg::SYNC_HIGH_RESET;
         sync_low_byte_ff <= slafp_pkg::SYNC_LOW_RESET;
      end else begin
         state_ff <= state_in;
         armed_ff <= armed_in;
         len_ff <= len_in;
         addr_ff <= addr_in;
         fill_ff <= fill_in;
         rd_idx_ff <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         sync_high_byte_ff <= sync_high_byte_in;
         sync_low_byte_ff <= sync_low_byte_in;
      end
      rsp_addr_ff <= rsp_addr_in;
      rsp_len_ff <= rsp_len_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tdata = {{(slafp_pkg::RSP_DATA_W - slafp_pkg::RSP_USED_W){1'b0}},
                       rsp_data_ff, rsp_idx_ff, rsp_len_ff, rsp_addr_ff};

endmodule

// File: hdl/slafp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; used for the payload store of the frame parser.
module slafp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the sync, length and address frame parser.
// Tracks the parser state per accepted item and checks each result in order.
// Depends on slafp_pkg and the top level sync_length_address_frame_parser.
module tb_top;

   localparam int BYTE_W = slafp_pkg::BYTE_W;
   localparam int PLEN_FIELD_W = slafp_pkg::PLEN_FIELD_W;
   localparam int INDEX_FIELD_W = slafp_pkg::INDEX_FIELD_W;
   localparam int LEN_W = slafp_pkg::LEN_W;
   localparam int STORE_ADDR_W = slafp_pkg::STORE_ADDR_W;
   localparam int MAX_PAYLOAD = slafp_pkg::MAX_PAYLOAD;
   localparam logic CSR_SYNC_HIGH = slafp_pkg::CSR_SYNC_HIGH;
   localparam logic CSR_SYNC_LOW = slafp_pkg::CSR_SYNC_LOW;
   localparam logic [BYTE_W-1:0] SYNC_HIGH_RESET = slafp_pkg::SYNC_HIGH_RESET;
   localparam logic [BYTE_W-1:0] SYNC_LOW_RESET = slafp_pkg::SYNC_LOW_RESET;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS = 120;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES = 400;

   typedef enum logic [1:0] {HUNT, TAKE_LEN, TAKE_ADDR, TAKE_DATA} parse_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]        node_address;
      logic [PLEN_FIELD_W-1:0]  payload_length;
      logic [INDEX_FIELD_W-1:0] byte_index;
      logic [BYTE_W-1:0]        data_byte;
      logic                     last;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_SYNC_HIGH;
   logic [7:0]  csr_wdata = '0;

   logic [BYTE_W-1:0] sync_high_shadow = SYNC_HIGH_RESET;
   logic [BYTE_W-1:0] sync_low_shadow = SYNC_LOW_RESET;
   parse_phase_type   parse_phase = HUNT;
   logic              armed = 1'b0;
   logic [LEN_W-1:0]  frame_len = '0;
   logic [BYTE_W-1:0] frame_addr = '0;
   logic [LEN_W-1:0]  fill_count = '0;
   logic [BYTE_W-1:0] payload_copy [MAX_PAYLOAD];

   frame_result_type pending_results [$];
   int mismatch_count = 0;
   int items_sent = 0;
   int cycle_count = 0;
   int hold_request = 0;
   int stall_left = 0;
   bit steady = 1'b0;

   sync_length_address_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic void clear_frame();
      parse_phase = HUNT;
      armed = 1'b0;
      frame_len = '0;
      frame_addr = '0;
      fill_count = '0;
   endfunction

   function automatic void track_byte(input logic [BYTE_W-1:0] value);
      frame_result_type r;
      case (parse_phase)
         HUNT: begin
            if (armed && value == sync_low_shadow)
               parse_phase = TAKE_LEN;
            else if (value == sync_high_shadow)
               armed = 1'b1;
         end
         TAKE_LEN: begin
            if (value > MAX_PAYLOAD) begin
               clear_frame();
            end else begin
               frame_len = value[LEN_W-1:0];
               parse_phase = TAKE_ADDR;
            end
         end
         TAKE_ADDR: begin
            frame_addr = value;
            if (frame_len == 0) begin
               r = '{node_address: value, payload_length: '0, byte_index: '0,
                     data_byte: '0, last: 1'b1};
               pending_results.push_back(r);
               clear_frame();
            end else begin
               parse_phase = TAKE_DATA;
            end
         end
         default: begin
            if (fill_count < frame_len) begin
               payload_copy[fill_count[STORE_ADDR_W-1:0]] = value;
               fill_count++;
            end
            if (fill_count >= frame_len) begin
               for (int i = 0; i < frame_len; i++) begin
                  r.node_address = frame_addr;
                  r.payload_length = frame_len;
                  r.byte_index = i[INDEX_FIELD_W-1:0];
                  r.data_byte = payload_copy[i[STORE_ADDR_W-1:0]];
                  r.last = (i + 1 == frame_len);
                  pending_results.push_back(r);
               end
               clear_frame();
            end
         end
      endcase
   endfunction

   task automatic report_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, detail);
   endtask

   always @(posedge clock) begin : result_check
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[13:8], rsp_tdata[18:14], rsp_tdata[26:19], rsp_tlast};
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result tdata %h tlast %b",
                                      rsp_tdata, rsp_tlast));
         end else begin
            want = pending_results.pop_front();
            if (got !== want || rsp_tdata[31:27] !== '0)
               report_mismatch($sformatf(
                  {"expected addr %h len %0d idx %0d data %h last %b, ",
                   "got addr %h len %0d idx %0d data %h last %b pad %h"},
                  want.node_address, want.payload_length, want.byte_index,
                  want.data_byte, want.last, got.node_address, got.payload_length,
                  got.byte_index, got.data_byte, got.last, rsp_tdata[31:27]));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      track_byte(value);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_sync_bytes(input logic [BYTE_W-1:0] high_byte,
                                 input logic [BYTE_W-1:0] low_byte);
      csr_we <= 1'b1;
      csr_index <= CSR_SYNC_HIGH;
      csr_wdata <= high_byte;
      @(posedge clock);
      csr_index <= CSR_SYNC_LOW;
      csr_wdata <= low_byte;
      @(posedge clock);
      csr_we <= 1'b0;
      sync_high_shadow = high_byte;
      sync_low_shadow = low_byte;
   endtask

   task automatic send_frame(input int len, input logic [BYTE_W-1:0] addr);
      send_byte(sync_high_shadow);
      send_byte(sync_low_shadow);
      send_byte(len[BYTE_W-1:0]);
      send_byte(addr);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic test_single_byte_frame();
      send_byte(SYNC_HIGH_RESET);
      send_byte(SYNC_LOW_RESET);
      send_byte(8'd1);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   task automatic test_empty_frame();
      send_byte(SYNC_HIGH_RESET);
      send_byte(SYNC_LOW_RESET);
      send_byte(8'd0);
      send_byte(8'hFF);
   endtask

   // The lone low sync byte must be ignored, as an abort also drops the arm flag.
   task automatic test_oversize_length();
      send_byte(SYNC_HIGH_RESET);
      send_byte(SYNC_LOW_RESET);
      send_byte(8'(MAX_PAYLOAD + 1));
      send_byte(SYNC_HIGH_RESET);
      send_byte(SYNC_LOW_RESET);
      send_byte(8'hFF);
      send_byte(SYNC_LOW_RESET);
   endtask

   task automatic test_arm_held_over_noise();
      send_byte(SYNC_HIGH_RESET);
      send_byte(8'h3C);
      send_byte(SYNC_LOW_RESET);
      send_byte(8'd1);
      send_byte(8'h81);
      send_byte(8'h7E);
   endtask

   task automatic test_equal_sync_bytes();
      wait_idle();
      set_sync_bytes(8'h5A, 8'h5A);
      send_byte(8'h5A);
      send_byte(8'h5A);
      send_byte(8'd0);
      send_byte(8'h77);
   endtask

   task automatic test_backpressure();
      wait_idle();
      set_sync_bytes(SYNC_HIGH_RESET, SYNC_LOW_RESET);
      steady = 1'b1;
      hold_request = HOLD_CYCLES;
      repeat (3) send_frame(MAX_PAYLOAD, 8'($urandom_range(0, 255)));
      steady = 1'b0;
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int setting;
      int target;
      int roll;
      int len;
      logic [BYTE_W-1:0] high_byte;
      logic [BYTE_W-1:0] low_byte;
      for (setting = 0; setting < 6; setting++) begin
         case (setting)
            0: {high_byte, low_byte} = {8'h00, 8'hFF};
            1: {high_byte, low_byte} = {8'hFF, 8'h00};
            2: {high_byte, low_byte} = {8'hFF, 8'hFF};
            3: {high_byte, low_byte} = {8'h00, 8'h00};
            4: {high_byte, low_byte} = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
            default: {high_byte, low_byte} = {SYNC_HIGH_RESET, SYNC_LOW_RESET};
         endcase
         wait_idle();
         set_sync_bytes(high_byte, low_byte);
         steady = (setting == 3);
         target = items_sent + RANDOM_ITEMS / 6;
         while (items_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
               if ($urandom_range(0, 9) == 0)
                  len = $urandom_range(MAX_PAYLOAD - 2, MAX_PAYLOAD);
               else if ($urandom_range(0, 2) == 0)
                  len = $urandom_range(5, 12);
               else
                  len = $urandom_range(0, 4);
               send_frame(len, 8'($urandom_range(0, 255)));
            end else if (roll < 82) begin
               send_byte(sync_high_shadow);
               send_byte(sync_low_shadow);
               send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end else if (roll < 92) begin
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end else if (roll < 96) begin
               send_byte(sync_high_shadow);
               send_byte(8'($urandom_range(0, 255)));
               send_byte(sync_low_shadow);
            end else begin
               send_byte(sync_high_shadow);
               send_byte(sync_low_shadow);
               send_byte(8'($urandom_range(0, MAX_PAYLOAD)));
            end
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_single_byte_frame();
      test_empty_frame();
      test_oversize_length();
      test_arm_held_over_noise();
      test_equal_sync_bytes();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
